/* src/ilid_pkg.sv */
// ----------------------------------------------------------------------------
// ilid_pkg
// shared types and codes of the indexed list core
// ----------------------------------------------------------------------------
package ilid_pkg;

	// value field width, position field width and input payload width
	localparam int VAL_W = 32;
	localparam int POS_W = 8;
	localparam int IN_W  = 40;

	// operation codes, carried on s_tuser
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// status codes, carried on m_tuser
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

/* src/ilid_cell.sv */
// ----------------------------------------------------------------------------
// ilid_cell
// one list slot: holds, shifts up, shifts down or loads a value
// ----------------------------------------------------------------------------
module ilid_cell
	import ilid_pkg::*;
#(
	parameter int IW = 4
) (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [IW-1:0]    sel_idx,
	input  logic [IW-1:0]    cell_id,
	input  logic [VAL_W-1:0] new_value,
	input  logic [VAL_W-1:0] left_value,
	input  logic [VAL_W-1:0] right_value,
	input  logic [VAL_W-1:0] removed_in,
	output logic [VAL_W-1:0] value,
	output logic [VAL_W-1:0] removed_out
);

	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] value_nxt;
	logic             hit;
	logic             above;

	assign hit   = (sel_idx == cell_id);
	assign above = (cell_id > sel_idx);

	always_comb begin
		value_nxt = value_q;
		if (cmd.ins) begin
			if (hit) begin
				value_nxt = new_value;
			end else if (above) begin
				value_nxt = left_value;
			end
		end else if (cmd.del) begin
			if (hit || above) begin
				value_nxt = right_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

	assign value       = value_q;
	// selected slot contributes its value to the removal chain
	assign removed_out = removed_in | (hit ? value_q : '0);

endmodule

/* src/indexed_list_insert_delete_core.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core
// ordered list of nonzero values with append, insert, delete and clear
// ----------------------------------------------------------------------------
// usage:
//   input channel s_*: one operation per transfer. s_tuser carries the op code
//   (append, insert, delete, clear), s_tdata the value and the list position.
//   output channel m_*: exactly one result per operation, in order. m_tuser
//   carries the status, m_tdata the removed value and the new list length.
// timing:
//   an accepted operation updates the whole row of cells at the same edge,
//   every slot shifting in parallel with its neighbor, so the result is shown
//   on m_* in the cycle after the input transfer. one operation per cycle is
//   sustained while the receiver takes each result; the parallel row update sets that figure.
// stall:
//   the result sits in an output register; s_tready stays high while that
//   register is empty or being drained, so a new transfer is taken in the same
//   cycle the receiver takes the previous result. a stalled receiver holds off
//   new input after one result is waiting.
// reset:
//   arst_n clears the length and the output valid; slot contents are left
//   as they are and only slots below the length are ever read.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core
	import ilid_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int OUT_W = ((VAL_W + CW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // item_value[31:0], position[39:32]
	input  logic [1:0]       s_tuser,   // op[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // removed_value[31:0], list_length above it
	output logic [1:0]       m_tuser    // status[1:0]
);

	localparam int IW = $clog2(DEPTH);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	// list length and output register
	logic [CW-1:0]    count_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [VAL_W-1:0] removed_q;
	logic [CW-1:0]    length_q;

	logic             accept;
	logic [1:0]       op;
	logic [VAL_W-1:0] in_value;
	logic [PW-1:0]    pos_w;
	logic [PW-1:0]    cnt_w;
	logic [PW-1:0]    last_w;
	logic [PW-1:0]    ins_idx_w;
	logic [PW-1:0]    del_idx_w;
	logic             full;
	logic             empty;

	// decoded operation
	cell_cmd_t        cmd;
	logic [IW-1:0]    sel_idx;
	logic [1:0]       status_nxt;
	logic [CW-1:0]    count_nxt;
	logic             is_delete;

	// cell row wiring
	logic [VAL_W-1:0] cell_value [DEPTH];
	logic [VAL_W-1:0] rm_chain   [DEPTH+1];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign op       = s_tuser;
	assign in_value = s_tdata[VAL_W-1:0];
	assign pos_w    = PW'(s_tdata[VAL_W +: POS_W]);
	assign cnt_w    = PW'(count_q);
	assign last_w   = cnt_w - PW'(1);
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// insert past the end clamps to append, delete past the end takes the last
	assign ins_idx_w = (pos_w > cnt_w) ? cnt_w : pos_w;
	assign del_idx_w = (pos_w >= last_w) ? last_w : pos_w;

	always_comb begin
		cmd        = '0;
		sel_idx    = '0;
		status_nxt = ST_OK;
		count_nxt  = count_q;
		is_delete  = 1'b0;
		case (op)
			OP_APPEND, OP_INSERT: begin
				// zero value is checked ahead of the full check
				if (in_value == '0) begin
					status_nxt = ST_ZERO;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					cmd.ins   = 1'b1;
					sel_idx   = (op == OP_APPEND) ? IW'(cnt_w) : IW'(ins_idx_w);
					count_nxt = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd.del   = 1'b1;
					is_delete = 1'b1;
					sel_idx   = IW'(del_idx_w);
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
				// clear: only the length matters, slot contents become stale
				count_nxt = '0;
			end
		endcase
	end

	// row of cells; the removed value travels down the chain by or
	assign rm_chain[0] = '0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		cell_cmd_t        cell_cmd;
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;

		assign cell_cmd = accept ? cmd : '0;
		assign left_v   = (k == 0) ? '0 : cell_value[(k == 0) ? 0 : k-1];
		assign right_v  = (k == DEPTH-1) ? '0 : cell_value[(k == DEPTH-1) ? k : k+1];

		ilid_cell #(
			.IW(IW)
		) u_cell (
			.clk         (clk),
			.cmd         (cell_cmd),
			.sel_idx     (sel_idx),
			.cell_id     (IW'(k)),
			.new_value   (in_value),
			.left_value  (left_v),
			.right_value (right_v),
			.removed_in  (rm_chain[k]),
			.value       (cell_value[k]),
			.removed_out (rm_chain[k+1])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on every input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_nxt;
			removed_q <= is_delete ? rm_chain[DEPTH] : '0;
			length_q  <= count_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = OUT_W'({length_q, removed_q});

endmodule

/* src/ilid_chk.sv */
// ----------------------------------------------------------------------------
// ilid_chk
// port-level checks of the indexed list core
// ----------------------------------------------------------------------------
module ilid_chk
	import ilid_pkg::*;
#(
	parameter int DEPTH = 16,
	localparam int CW    = $clog2(DEPTH + 1),
	localparam int OUT_W = ((VAL_W + CW + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic [1:0]       s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [1:0]       m_tuser
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input is taken whenever the result register is free or being drained
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output register");

	// a clear transfer yields an ok result with empty list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_CLEAR) |=>
			m_tvalid && (m_tuser == ST_OK) && (m_tdata[VAL_W +: CW] == '0)
			&& (m_tdata[VAL_W-1:0] == '0))
		else $error("clear result wrong");

	// an empty-list status reports zero length and nothing removed
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |->
			(m_tdata[VAL_W +: CW] == '0) && (m_tdata[VAL_W-1:0] == '0))
		else $error("empty status with data");

	// length never exceeds capacity
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[VAL_W +: CW] <= CW'(DEPTH)))
		else $error("length beyond capacity");

endmodule

bind indexed_list_insert_delete_core ilid_chk #(.DEPTH(DEPTH)) u_ilid_chk (.*);

/* bench/list_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker
// watches both channels of the list core, predicts every result and compares
// ----------------------------------------------------------------------------
module list_checker
	import ilid_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int LEN_W = 5,
	parameter int OUT_W = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // item_value[31:0], position[39:32]
	input  logic [1:0]       s_tuser,   // op[1:0]
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // removed_value[31:0], list_length above it
	input  logic [1:0]       m_tuser,   // status[1:0]
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] removed;
		logic [LEN_W-1:0] length;
	} list_result_t;

	// shadow copy of the list contents
	logic [VAL_W-1:0] shadow_slots [DEPTH];
	int               shadow_len;
	list_result_t     result_q [$];

	// applies one operation to the shadow list and returns its answer
	function automatic list_result_t list_step(logic [1:0] op, logic [VAL_W-1:0] val,
		logic [POS_W-1:0] pos);
		list_result_t r;
		int           idx;
		r = '{ST_OK, '0, '0};
		case (op)
			OP_APPEND, OP_INSERT: begin
				idx = (op == OP_APPEND || int'(pos) > shadow_len) ? shadow_len : int'(pos);
				if (val == '0)
					r.status = ST_ZERO;
				else if (shadow_len >= DEPTH)
					r.status = ST_FULL;
				else begin
					for (int k = shadow_len; k > idx; k--)
						shadow_slots[k] = shadow_slots[k-1];
					shadow_slots[idx] = val;
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (shadow_len == 0)
					r.status = ST_EMPTY;
				else begin
					idx = (int'(pos) >= shadow_len - 1) ? shadow_len - 1 : int'(pos);
					r.removed = shadow_slots[idx];
					for (int k = idx; k + 1 < shadow_len; k++)
						shadow_slots[k] = shadow_slots[k+1];
					shadow_len--;
					shadow_slots[shadow_len] = '0;
				end
			end
			default: shadow_len = 0;
		endcase
		r.length = shadow_len[LEN_W-1:0];
		return r;
	endfunction

	task automatic note_mismatch(string what, list_result_t e, list_result_t g);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: expected status %0d removed %h length %0d, got status %0d removed %h length %0d",
				$realtime, what, e.status, e.removed, e.length, g.status, g.removed, g.length);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		list_result_t got_r;
		list_result_t exp_r;
		if (!arst_n) begin
			result_q.delete();
			shadow_len = 0;
			pending    = 0;
		end else begin
			// a result leaving now belongs to an earlier operation, so pop first
			if (m_tvalid && m_tready) begin
				got_r = '{m_tuser, m_tdata[VAL_W-1:0], m_tdata[VAL_W +: LEN_W]};
				if (result_q.size() == 0)
					note_mismatch("result with nothing pending", '0, got_r);
				else begin
					exp_r = result_q.pop_front();
					if (got_r != exp_r)
						note_mismatch("result mismatch", exp_r, got_r);
				end
			end
			if (s_tvalid && s_tready)
				result_q.push_back(list_step(s_tuser, s_tdata[VAL_W-1:0],
					s_tdata[VAL_W +: POS_W]));
			pending = result_q.size();
		end
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives list operations into the core under varying back-pressure and
// reports the verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module tb_top;
	import ilid_pkg::*;

	localparam int DEPTH       = 16;
	localparam int LEN_W       = $clog2(DEPTH + 1);
	localparam int OUT_W       = ((VAL_W + LEN_W + 7) / 8) * 8;
	localparam int LIMIT       = 300000;   // cycles, far beyond the slowest clean run
	localparam int HOLD_CYCLES = 300;      // long receiver stall to back up the core
	localparam int SETTLE      = 8;        // trailing cycles after the last result

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;   // item_value[31:0], position[39:32]
	logic [1:0]       s_tuser  = OP_APPEND;   // op[1:0]
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;          // removed_value[31:0], list_length above it
	logic [1:0]       m_tuser;          // status[1:0]

	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	int   tx_idle_pct = 6;     // chance per transfer that the sender inserts a gap
	int   rx_idle_pct = 53;    // chance per cycle that the receiver stalls
	int   hold_req    = 0;     // running count of requested long receiver stalls

	always #10 clk = ~clk;

	indexed_list_insert_delete_core #(.DEPTH(DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	list_checker #(.DEPTH(DEPTH), .LEN_W(LEN_W), .OUT_W(OUT_W)) u_list_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("indexed_list_insert_delete_core verification failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off per request
	initial begin
		int holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// offers one operation and returns right after its transfer edge
	task automatic push_op(logic [1:0] op, logic [VAL_W-1:0] val, logic [POS_W-1:0] pos);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {pos, val};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// mostly random values, with zero and the extremes mixed in
	function automatic logic [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 9)
			return '1;
		if (roll < 12)
			return 1;
		return $urandom;
	endfunction

	// positions mostly near the live range of the list, sometimes anywhere
	function automatic logic [POS_W-1:0] pick_pos();
		if ($urandom_range(3) == 0)
			return POS_W'($urandom_range(255));
		return POS_W'($urandom_range(DEPTH + 1));
	endfunction

	// random operations, in stretches that randomly favour growing or draining
	// so the list keeps passing through empty, partial and full
	task automatic run_random(int n);
		int roll;
		bit grow;
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 0)
				grow = 1'($urandom_range(1));
			roll = $urandom_range(99);
			if (roll < 2)
				push_op(OP_CLEAR, $urandom, POS_W'($urandom));
			else if (roll < (grow ? 37 : 17))
				push_op(OP_APPEND, pick_value(), POS_W'($urandom));
			else if (roll < (grow ? 77 : 32))
				push_op(OP_INSERT, pick_value(), pick_pos());
			else
				push_op(OP_DELETE, $urandom, pick_pos());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty delete, zero values, front, middle and past-end positions
		push_op(OP_DELETE, 32'hDEAD_BEEF, 8'd0);
		push_op(OP_APPEND, '0, 8'd0);
		push_op(OP_INSERT, '0, 8'd0);
		push_op(OP_APPEND, '1, 8'd255);
		push_op(OP_INSERT, 32'h0000_0001, 8'd0);
		push_op(OP_INSERT, 32'h8000_0000, 8'd255);
		push_op(OP_INSERT, 32'h1234_5678, 8'd1);
		push_op(OP_DELETE, 32'hFFFF_FFFF, 8'd1);
		push_op(OP_DELETE, '0, 8'd255);
		push_op(OP_DELETE, '0, 8'd0);
		push_op(OP_CLEAR, '1, 8'd255);

		// fill to capacity, then knock on the full list
		for (int k = 0; k < DEPTH; k++) begin
			if (k % 2 == 1)
				push_op(OP_INSERT, $urandom | 1, 8'd0);
			else
				push_op(OP_APPEND, $urandom | 1, POS_W'($urandom));
		end
		push_op(OP_APPEND, 32'hA5A5_A5A5, 8'd0);
		push_op(OP_INSERT, 32'h5A5A_5A5A, 8'd3);
		push_op(OP_INSERT, 32'h0F0F_0F0F, 8'd255);
		push_op(OP_INSERT, '0, 8'd2);         // zero check wins over full
		push_op(OP_DELETE, '0, 8'(DEPTH - 1)); // exactly the last entry
		push_op(OP_CLEAR, '0, 8'd0);

		// light sender gaps, heavy receiver stalls
		run_random(200);
		hold_req <= hold_req + 1;   // receiver stalls long while the sender keeps offering
		run_random(100);
		s_tvalid <= 1'b0;   // sender pauses until the core has drained
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		run_random(130);

		// heavy sender gaps, light receiver stalls
		tx_idle_pct = 53;
		rx_idle_pct = 6;
		run_random(430);

		// full rate both ways, with one more long hold-off
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(200);
		hold_req <= hold_req + 1;
		run_random(230);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("indexed_list_insert_delete_core verification clean");
		else
			$display("indexed_list_insert_delete_core verification failed");
		$finish;
	end

endmodule
